/* rtl/core/dcwg_pkg.sv */
// Shared types, constants and the sine table builder for the waveform generator.
package dcwg_pkg;

    // Default build parameters
    localparam int unsigned LANE_COUNT_DEF      = 2;
    localparam int unsigned PHASE_BITS_DEF      = 32;
    localparam int unsigned SINE_TABLE_BITS_DEF = 10;
    localparam int unsigned PHASE_STEP_DEF      = 10937131;

    // Configuration port geometry and register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_WORD_LEFT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_WORD_RIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME_LEFT     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME_RIGHT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAVE_LEFT       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAVE_RIGHT      = 3'd5;

    // Register reset values
    localparam logic [31:0] FREQ_WORD_RST = 32'd9836504;
    localparam logic [15:0] VOLUME_RST    = 16'd12124;

    // Wave select codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [1:0] WAVE_SAW      = 2'd3;

    // Nudge field codes (two's complement +1 and -1)
    localparam logic [1:0] NUDGE_UP   = 2'b01;
    localparam logic [1:0] NUDGE_DOWN = 2'b11;

    // Q30 fixed point helpers for the table build
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Pipeline control handed from the top level to each lane
    typedef struct packed {
        logic accept;   // an item enters this cycle
        logic advance;  // all stages move this cycle
    } t_pipe_ctl;

    // One quarter-wave entry: round(2^15 * sin(pi/2 * k / 2^tbits)), Taylor series in Q30
    function automatic logic [15:0] sine_entry(int unsigned k, int unsigned tbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (longint'(k) * HALF_PI_Q30) >> tbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32768) begin
            s = 64'd32768;
        end
        return 16'(s);
    endfunction

endpackage

/* rtl/core/dual_channel_waveform_generator_core.sv */
// Top level: config registers, pipeline control, channel lanes and frame merge.
// An accepted item passes through the angle, shape/ROM and scale stages to become a frame.
// Throughput: one item per cycle; each lane's sine ROM read and scaling multiply are
// pipelined, so the only stall is the output register waiting on i_out_ready.
// Reset (synchronous, active low) zeroes phase accumulators and offsets, empties the
// pipeline and loads the default tuning words, volumes and sine waves.
module dual_channel_waveform_generator_core #(
    parameter int unsigned LANE_COUNT      = dcwg_pkg::LANE_COUNT_DEF,
    parameter int unsigned PHASE_BITS      = dcwg_pkg::PHASE_BITS_DEF,
    parameter int unsigned SINE_TABLE_BITS = dcwg_pkg::SINE_TABLE_BITS_DEF,
    parameter int unsigned PHASE_STEP      = dcwg_pkg::PHASE_STEP_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_nudge_left,
    input  logic [1:0]                      i_nudge_right,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [15:0]                     o_left_sample,
    output logic [15:0]                     o_right_sample,
    input  logic                            i_cfg_we,
    input  logic [dcwg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dcwg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [31:0] r_freq   [2];
    logic [15:0] r_volume [2];
    logic [1:0]  r_wave   [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq[0]   <= dcwg_pkg::FREQ_WORD_RST;
            r_freq[1]   <= dcwg_pkg::FREQ_WORD_RST;
            r_volume[0] <= dcwg_pkg::VOLUME_RST;
            r_volume[1] <= dcwg_pkg::VOLUME_RST;
            r_wave[0]   <= dcwg_pkg::WAVE_SINE;
            r_wave[1]   <= dcwg_pkg::WAVE_SINE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dcwg_pkg::CFG_FREQ_WORD_LEFT:  r_freq[0]   <= i_cfg_data;
                dcwg_pkg::CFG_FREQ_WORD_RIGHT: r_freq[1]   <= i_cfg_data;
                dcwg_pkg::CFG_VOLUME_LEFT:     r_volume[0] <= i_cfg_data[15:0];
                dcwg_pkg::CFG_VOLUME_RIGHT:    r_volume[1] <= i_cfg_data[15:0];
                dcwg_pkg::CFG_WAVE_LEFT:       r_wave[0]   <= i_cfg_data[1:0];
                dcwg_pkg::CFG_WAVE_RIGHT:      r_wave[1]   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Pipeline occupancy: bit 0 angle stage, bit 1 shape stage, bit 2 output stage
    logic [2:0]          r_valid;
    dcwg_pkg::t_pipe_ctl w_ctl;

    assign w_ctl.advance = !r_valid[2] || i_out_ready;
    assign w_ctl.accept  = i_in_valid && w_ctl.advance;
    assign o_in_ready    = w_ctl.advance;
    assign o_out_valid   = r_valid[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_ctl.advance) begin
            r_valid <= {r_valid[1:0], w_ctl.accept};
        end
    end

    // Channel lanes
    logic [1:0]  w_nudge  [2];
    logic [15:0] w_sample [2];

    assign w_nudge[0] = i_nudge_left;
    assign w_nudge[1] = i_nudge_right;

    for (genvar ch = 0; ch < 2; ch++) begin : g_lane
        if (ch < LANE_COUNT) begin : g_on
            dcwg_lane #(
                .PHASE_BITS      (PHASE_BITS),
                .SINE_TABLE_BITS (SINE_TABLE_BITS),
                .PHASE_STEP      (PHASE_STEP)
            ) u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_freq_word (r_freq[ch]),
                .i_volume    (r_volume[ch]),
                .i_wave      (r_wave[ch]),
                .i_nudge     (w_nudge[ch]),
                .o_sample    (w_sample[ch])
            );
        end else begin : g_off
            // absent channel reads as silence
            assign w_sample[ch] = '0;
        end
    end

    // Frame merge
    assign o_left_sample  = w_sample[0];
    assign o_right_sample = w_sample[1];

`ifndef SYNTHESIS
    a_accept_fills_stage_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.accept |=> r_valid[0])
        else $error("accepted item did not enter the angle stage");

    a_stall_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ctl.advance |=> $stable(r_valid))
        else $error("pipeline occupancy changed during a stall");

    a_shape_moves_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.advance && r_valid[1]) |=> r_valid[2])
        else $error("shaped item lost on its way to the output stage");

    a_ready_tracks_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[2] && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while the output frame is stalled");

    a_absent_channel_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((LANE_COUNT > 1) || (o_right_sample == 16'd0)))
        else $error("absent right channel produced a nonzero sample");
`endif

endmodule

/* rtl/core/dcwg_lane.sv */
// One synthesis channel: phase state, wave shaping with sine ROM, amplitude scaling.
module dcwg_lane #(
    parameter int unsigned PHASE_BITS      = dcwg_pkg::PHASE_BITS_DEF,
    parameter int unsigned SINE_TABLE_BITS = dcwg_pkg::SINE_TABLE_BITS_DEF,
    parameter int unsigned PHASE_STEP      = dcwg_pkg::PHASE_STEP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dcwg_pkg::t_pipe_ctl i_ctl,
    input  logic [31:0]         i_freq_word,
    input  logic [15:0]         i_volume,
    input  logic [1:0]          i_wave,
    input  logic [1:0]          i_nudge,
    output logic [15:0]         o_sample
);

    localparam int unsigned QLEN = 1 << SINE_TABLE_BITS;
    localparam int unsigned IW   = SINE_TABLE_BITS + 1;
    localparam int unsigned FW   = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int unsigned SW   = ((PHASE_BITS > 31) ? PHASE_BITS : 31) + 1;
    localparam logic [SW-1:0] STEP_W = SW'(PHASE_STEP);
    localparam logic [SW-1:0] FULL_W = SW'(1) << PHASE_BITS;

    localparam logic [16:0] TRI_QUARTER = 17'd32768;
    localparam logic [16:0] TRI_HALF    = 17'd65536;
    localparam logic [16:0] TRI_3QUART  = 17'd98304;
    localparam logic [15:0] LEVEL_FULL  = 16'h8000;

    typedef logic [15:0] t_rom [0:QLEN];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= QLEN; k++) begin
            rom[k] = dcwg_pkg::sine_entry(k, SINE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // ---------------- phase state, updated on accept ----------------
    logic [PHASE_BITS-1:0] r_acc, n_acc;
    logic [PHASE_BITS-1:0] r_off, n_off;
    logic [FW-1:0]         w_freq_ext;
    logic [SW-1:0]         w_off_ext;

    assign w_freq_ext = FW'(i_freq_word);
    assign w_off_ext  = SW'(r_off);
    assign n_acc      = r_acc + w_freq_ext[PHASE_BITS-1:0];

    // Offset nudge: a step down clamps at zero; a step up that would wrap past the top is dropped
    always_comb begin
        n_off = r_off;
        case (i_nudge)
            dcwg_pkg::NUDGE_UP: begin
                if ((w_off_ext + STEP_W) < FULL_W) begin
                    n_off = PHASE_BITS'(w_off_ext + STEP_W);
                end
            end
            dcwg_pkg::NUDGE_DOWN: begin
                if (w_off_ext < STEP_W) begin
                    n_off = '0;
                end else begin
                    n_off = PHASE_BITS'(w_off_ext - STEP_W);
                end
            end
            default: n_off = r_off;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_off <= '0;
        end else if (i_ctl.accept) begin
            r_acc <= n_acc;
            r_off <= n_off;
        end
    end

    // Stage A: angle for the accepted item
    logic [PHASE_BITS-1:0] r_angle;

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_angle <= r_acc + r_off;
        end
    end

    // ---------------- stage B: shape decode and ROM read ----------------
    logic [47:0]   w_a;
    logic [1:0]    w_quad;
    logic [IW-1:0] w_idx_raw;
    logic [IW-1:0] w_idx;
    logic [16:0]   w_u;
    logic [15:0]   w_saw;
    logic [15:0]   w_level;
    logic          w_neg;
    logic          w_sine;

    assign w_a       = 48'(r_angle) << (48 - PHASE_BITS);
    assign w_quad    = w_a[47:46];
    assign w_idx_raw = {1'b0, w_a[45 -: SINE_TABLE_BITS]};
    assign w_idx     = w_quad[0] ? (IW'(QLEN) - w_idx_raw) : w_idx_raw;
    assign w_u       = w_a[47:31];
    assign w_saw     = w_a[47:32];

    always_comb begin
        w_level = '0;
        w_neg   = 1'b0;
        w_sine  = 1'b0;
        case (i_wave)
            dcwg_pkg::WAVE_SINE: begin
                w_sine = 1'b1;
                w_neg  = w_quad[1];
            end
            dcwg_pkg::WAVE_SQUARE: begin
                w_level = LEVEL_FULL;
                w_neg   = !((r_angle != '0) && !w_a[47]);
            end
            dcwg_pkg::WAVE_TRIANGLE: begin
                if (w_u <= TRI_QUARTER) begin
                    w_level = w_u[15:0];
                end else if (w_u < TRI_3QUART) begin
                    if (w_u <= TRI_HALF) begin
                        w_level = 16'(TRI_HALF - w_u);
                    end else begin
                        w_level = 16'(w_u - TRI_HALF);
                        w_neg   = 1'b1;
                    end
                end else begin
                    w_level = 16'(18'h20000 - {1'b0, w_u});
                    w_neg   = 1'b1;
                end
            end
            default: begin
                w_neg = w_saw[15];
                if (w_saw[15]) begin
                    w_level = 16'(17'h10000 - {1'b0, w_saw});
                end else begin
                    w_level = w_saw;
                end
            end
        endcase
    end

    logic [15:0] r_rom_q;
    logic [15:0] r_level_b;
    logic        r_neg_b;
    logic        r_sine_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_rom_q   <= SINE_ROM[w_idx];
            r_level_b <= w_level;
            r_neg_b   <= w_neg;
            r_sine_b  <= w_sine;
        end
    end

    // ---------------- stage C: amplitude scaling ----------------
    logic [15:0] w_vol_sat;
    logic [30:0] w_amp_full;
    logic [14:0] w_amp;
    logic [15:0] w_level_c;
    logic [30:0] w_prod;

    // amp = floor(32767 * vol / 2^15), built as (vol << 15) - vol
    assign w_vol_sat  = (i_volume > LEVEL_FULL) ? LEVEL_FULL : i_volume;
    assign w_amp_full = {w_vol_sat, 15'd0} - 31'(w_vol_sat);
    assign w_amp      = w_amp_full[29:15];
    assign w_level_c  = r_sine_b ? r_rom_q : r_level_b;
    assign w_prod     = 31'(w_amp) * 31'(w_level_c);

    logic [15:0] r_mag;
    logic        r_neg_c;

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_mag   <= w_prod[30:15];
            r_neg_c <= r_neg_b;
        end
    end

    assign o_sample = r_neg_c ? (16'd0 - r_mag) : r_mag;

endmodule
